// ===== rtl/shcg_pkg.sv =====
// Shared types, constants and helper functions for the serial command GPIO bridge.
package shcg_pkg;

  // Default line buffer depth
  localparam int LINE_DEPTH_DEF = 16;
  // Only the leading bytes of a line are ever inspected (names and hex digits)
  localparam int KEEP_BYTES = 8;
  localparam int KEEP_IW    = $clog2(KEEP_BYTES);

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_NINE = "9";

  // Byte i of a name sits in element i; zero pads the tail
  localparam logic [7:0][7:0] NAME_SETUP  = {CH_NUL, CH_NUL, "0", "p", "u", "t", "e", "s"};
  localparam logic [7:0][7:0] NAME_MAW    = {CH_NUL, CH_NUL, CH_NUL, CH_NUL,
                                             "=", "W", "A", "M"};
  localparam logic [7:0][7:0] NAME_RST    = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL,
                                             "T", "S", "R"};
  localparam logic [7:0][7:0] REPLY_SETUP = {CH_NUL, CH_CR, "1", "p", "u", "t", "e", "s"};
  localparam logic [3:0]      REPLY_LEN   = 4'd7;
  localparam logic [3:0]      REPORT_LEN  = 4'd8;

  // One processed item handed to the transmit sequencer
  typedef struct packed {
    logic [7:0][7:0] msg;
    logic [3:0]      cnt;     // characters to send, zero means none
    logic [15:0]     word;    // output word after this item
    logic            rep_en;  // reporting enable after this item
  } shcg_item_t;

  // Output pin levels
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    logic [7:0] e;
    logic [7:0] f;
  } shcg_pins_t;

  // Prefix match, stops at the end of the shorter string
  function automatic logic line_match(logic [7:0][7:0] line, logic [7:0][7:0] name);
    logic m;
    m = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      m = (name[i] == CH_NUL) || (line[i] == CH_NUL) || ((line[i] == name[i]) && m);
    end
    return m;
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = (c > CH_NINE) ? (c - 8'd55) : (c - 8'd48);
    return t[3:0];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h37 + {4'd0, d});
  endfunction

  // Collect the input pins into the report word
  function automatic logic [15:0] gather_pins(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                              logic [7:0] d, logic [7:0] e, logic [7:0] f);
    return {c[7], a[6], d[6], a[7], c[6], b[4], c[5], a[5],
            c[4], e[4], b[3], e[5], f[3], b[0], f[2], b[1]};
  endfunction

  // Spread the output word onto the port bits
  function automatic shcg_pins_t scatter_word(logic [15:0] w);
    shcg_pins_t p;
    p   = '0;
    p.a = {3'b000, w[6], w[8], w[10], 2'b00};
    p.b = {w[2], w[4], 3'b000, w[0], 2'b00};
    p.d = {w[14], 3'b000, w[5], w[7], w[1], w[3]};
    p.e = {4'b0000, w[15], w[9], w[11], 1'b0};
    p.f = {3'b000, w[12], 2'b00, w[13], 1'b0};
    return p;
  endfunction

endpackage

// ===== rtl/shcg_cmd.sv =====
// Line collection, command decode and bridge state.
module shcg_cmd import shcg_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] rpt_word,
  output shcg_item_t  item
);

  localparam int LW = $clog2(LINE_DEPTH + 1);

  logic [7:0]      lbuf_r   [KEEP_BYTES];
  logic [7:0]      lbuf_nxt [KEEP_BYTES];
  logic [LW-1:0]   len_r, len_nxt;
  logic            rep_r, rep_nxt;
  logic [15:0]     word_r, word_nxt;
  logic [7:0][7:0] eff;
  logic            room, in_keep;

  assign room    = len_r < LW'(LINE_DEPTH);
  assign in_keep = len_r < LW'(KEEP_BYTES);

  // Line as seen once the terminator has been placed
  always_comb begin
    for (int i = 0; i < KEEP_BYTES; i++) begin
      eff[i] = (len_r == LW'(i)) ? CH_NUL : lbuf_r[i];
    end
  end

  // Next state and message for the pending item
  always_comb begin
    lbuf_nxt = lbuf_r;
    len_nxt  = len_r;
    rep_nxt  = rep_r;
    word_nxt = word_r;
    item.msg = '0;
    item.cnt = '0;
    if (cmd) begin
      if (rep_r) begin
        item.msg = {CH_CR, hex_char(rpt_word[3:0]), hex_char(rpt_word[7:4]),
                    hex_char(rpt_word[11:8]), hex_char(rpt_word[15:12]), "=", "W", "E"};
        item.cnt = REPORT_LEN;
      end
    end else if (rx_byte == CH_CR) begin
      if (room && in_keep) begin
        lbuf_nxt[len_r[KEEP_IW-1:0]] = CH_NUL;
      end
      len_nxt = '0;
      if (line_match(eff, NAME_SETUP)) begin
        item.msg = REPLY_SETUP;
        item.cnt = REPLY_LEN;
        rep_nxt  = 1'b1;
      end else if (line_match(eff, NAME_MAW)) begin
        word_nxt = {hex_val(eff[4]), hex_val(eff[5]), hex_val(eff[6]), hex_val(eff[7])};
      end else if (line_match(eff, NAME_RST)) begin
        rep_nxt = 1'b0;
      end
    end else if (room) begin
      if (in_keep) begin
        lbuf_nxt[len_r[KEEP_IW-1:0]] = rx_byte;
      end
      len_nxt = len_r + LW'(1);
    end
    item.word   = word_nxt;
    item.rep_en = rep_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEEP_BYTES; i++) begin
        lbuf_r[i] <= CH_NUL;
      end
      len_r  <= '0;
      rep_r  <= 1'b0;
      word_r <= '0;
    end else if (go) begin
      lbuf_r <= lbuf_nxt;
      len_r  <= len_nxt;
      rep_r  <= rep_nxt;
      word_r <= word_nxt;
    end
  end

endmodule

// ===== rtl/shcg_tx.sv =====
// Result sequencer: sends the characters of one processed item, one per transfer.
module shcg_tx import shcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  shcg_item_t  item,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  tx_byte,
  output logic        tx_valid,
  output logic        last,
  output logic [15:0] word,
  output logic        rep_en
);

  logic            busy_r;
  logic [2:0]      idx_r;
  logic [7:0][7:0] msg_r;
  logic [3:0]      cnt_r;
  logic [15:0]     word_r;
  logic            rep_r;
  logic            done;

  assign tx_valid  = cnt_r != 4'd0;
  assign last      = !tx_valid || ({1'b0, idx_r} == (cnt_r - 4'd1));
  assign tx_byte   = tx_valid ? msg_r[idx_r] : CH_NUL;
  assign word      = word_r;
  assign rep_en    = rep_r;
  assign out_valid = busy_r;
  assign done      = busy_r && out_ready && last;
  assign free      = !busy_r || done;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_ready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (load) begin
      msg_r  <= item.msg;
      cnt_r  <= item.cnt;
      word_r <= item.word;
      rep_r  <= item.rep_en;
    end
  end

endmodule

// ===== rtl/serial_hex_command_gpio_bridge.sv =====
// Top level of the serial command GPIO bridge.
//
// Input channel (in_valid/in_ready): one item per transfer, either a received
// serial byte (in_cmd = 0) or a report tick (in_cmd = 1) with pin levels.
// Result channel (out_valid/out_ready): one transfer per character sent; an
// item that sends nothing gives one transfer with out_tx_valid low. out_last
// marks the final transfer of an item. Pin outputs and out_reporting_on show
// the state after the item in every transfer of that item.
// The first result of an item is offered once the item has passed the input
// register and been loaded into the result sequencer. An item holds the
// sequencer until all of its results, one to eight, have transferred; the
// input register takes the next item meanwhile.
// Reset clears the line buffer, the line length, reporting and the output
// word. When the receiver stalls, the current result holds, one more item
// waits in the input register and in_ready then drops.
module serial_hex_command_gpio_bridge import shcg_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_pins_a_in,
  input  logic [7:0] in_pins_b_in,
  input  logic [7:0] in_pins_c_in,
  input  logic [7:0] in_pins_d_in,
  input  logic [7:0] in_pins_e_in,
  input  logic [7:0] in_pins_f_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_last,
  output logic [7:0] out_pins_a_out,
  output logic [7:0] out_pins_b_out,
  output logic [7:0] out_pins_d_out,
  output logic [7:0] out_pins_e_out,
  output logic [7:0] out_pins_f_out,
  output logic       out_reporting_on
);

  logic        in_vld_r;
  logic        cmd_r;
  logic [7:0]  rx_r;
  logic [15:0] rpt_r;
  logic        load, tx_free;
  shcg_item_t  item;
  logic [15:0] word;
  shcg_pins_t  pins;

  assign load     = in_vld_r && tx_free;
  assign in_ready = !in_vld_r || load;

  // Input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  // Input register payload, pins gathered on capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      rx_r  <= in_rx_byte;
      rpt_r <= gather_pins(in_pins_a_in, in_pins_b_in, in_pins_c_in,
                           in_pins_d_in, in_pins_e_in, in_pins_f_in);
    end
  end

  shcg_cmd #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_cmd (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (load),
    .cmd     (cmd_r),
    .rx_byte (rx_r),
    .rpt_word(rpt_r),
    .item    (item)
  );

  shcg_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .item     (item),
    .free     (tx_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tx_byte  (out_tx_byte),
    .tx_valid (out_tx_valid),
    .last     (out_last),
    .word     (word),
    .rep_en   (out_reporting_on)
  );

  // Output word onto the port bits
  assign pins           = scatter_word(word);
  assign out_pins_a_out = pins.a;
  assign out_pins_b_out = pins.b;
  assign out_pins_d_out = pins.d;
  assign out_pins_e_out = pins.e;
  assign out_pins_f_out = pins.f;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the serial command GPIO bridge, with its own line-buffer predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import shcg_pkg::*;

  localparam int LINE_DEPTH  = LINE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 2000;  // far above the longest receiver hold
  localparam int HOLD_CYCLES = 60;

  localparam string SETUP_CMD   = "setup0";
  localparam string MAW_CMD     = "MAW=";
  localparam string RST_CMD     = "RST";
  localparam string SETUP_REPLY = "setup1";
  localparam string REPORT_HEAD = "EW=";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_UPPER_A = "A";

  typedef enum logic {
    KIND_RX_BYTE = 1'b0,
    KIND_TICK    = 1'b1
  } item_kind_e;

  // One input item
  typedef struct {
    item_kind_e kind;
    logic [7:0] rx;
    logic [7:0] pa, pb, pc, pd, pe, pf;
  } bridge_item_t;

  // One result transfer
  typedef struct {
    logic [7:0] ch;
    logic       ch_valid;
    logic       fin;
    logic [7:0] pa, pb, pd, pe, pf;
    logic       rep;
  } tx_frame_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_cmd = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic [7:0] in_pins_a_in = 8'h00;
  logic [7:0] in_pins_b_in = 8'h00;
  logic [7:0] in_pins_c_in = 8'h00;
  logic [7:0] in_pins_d_in = 8'h00;
  logic [7:0] in_pins_e_in = 8'h00;
  logic [7:0] in_pins_f_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_tx_valid;
  logic       out_last;
  logic [7:0] out_pins_a_out;
  logic [7:0] out_pins_b_out;
  logic [7:0] out_pins_d_out;
  logic [7:0] out_pins_e_out;
  logic [7:0] out_pins_f_out;
  logic       out_reporting_on;

  // predicted bridge state
  logic [7:0]  line_mem [LINE_DEPTH];
  int          line_fill;
  logic        reports_on;
  logic [15:0] held_word;
  tx_frame_t   frame_q [$];

  // run control and statistics
  bit no_idle;
  int rx_hold_cycles;
  int quiet_cycles;
  int err_count;
  int items_sent;
  int frames_checked;
  int reports_sent;
  int word_loads;
  int bytes_dropped;
  int long_holds;

  serial_hex_command_gpio_bridge #(.LINE_DEPTH(LINE_DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .in_pins_a_in     (in_pins_a_in),
    .in_pins_b_in     (in_pins_b_in),
    .in_pins_c_in     (in_pins_c_in),
    .in_pins_d_in     (in_pins_d_in),
    .in_pins_e_in     (in_pins_e_in),
    .in_pins_f_in     (in_pins_f_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_tx_valid     (out_tx_valid),
    .out_last         (out_last),
    .out_pins_a_out   (out_pins_a_out),
    .out_pins_b_out   (out_pins_b_out),
    .out_pins_d_out   (out_pins_d_out),
    .out_pins_e_out   (out_pins_e_out),
    .out_pins_f_out   (out_pins_f_out),
    .out_reporting_on (out_reporting_on)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] hex_ascii(logic [3:0] d);
    return (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_UPPER_A + {4'd0, d} - 8'd10);
  endfunction

  // letters count from 'A', everything else from '0'; low nibble kept
  function automatic logic [3:0] nibble_of(logic [7:0] c);
    int v;
    v = (c > CH_NINE) ? int'(c) - 55 : int'(c) - 48;
    return v[3:0];
  endfunction

  // prefix compare, stops at the end of the shorter string
  function automatic bit line_starts(string name);
    logic [7:0] a, b;
    for (int i = 0; i <= LINE_DEPTH; i++) begin
      a = (i < LINE_DEPTH) ? line_mem[i] : CH_NUL;
      b = (i < name.len()) ? name[i] : CH_NUL;
      if (a == CH_NUL || b == CH_NUL) return 1'b1;
      if (a != b) return 1'b0;
    end
    return 1'b1;
  endfunction

  // result transfer carrying the pin state after the item
  function automatic tx_frame_t frame_for(logic [7:0] ch, logic valid_ch, logic fin);
    tx_frame_t f;
    logic [15:0] w;
    w = held_word;
    f.ch = valid_ch ? ch : 8'h00;
    f.ch_valid = valid_ch;
    f.fin = fin;
    f.pa = '0;
    f.pa[4] = w[6];  f.pa[3] = w[8];  f.pa[2] = w[10];
    f.pb = '0;
    f.pb[7] = w[2];  f.pb[6] = w[4];  f.pb[2] = w[0];
    f.pd = '0;
    f.pd[7] = w[14]; f.pd[3] = w[5];  f.pd[2] = w[7]; f.pd[1] = w[1]; f.pd[0] = w[3];
    f.pe = '0;
    f.pe[3] = w[15]; f.pe[2] = w[9];  f.pe[1] = w[11];
    f.pf = '0;
    f.pf[4] = w[12]; f.pf[1] = w[13];
    f.rep = reports_on;
    return f;
  endfunction

  // update line state and queue the characters one item sends
  task automatic bridge_step(bridge_item_t it);
    logic [7:0]  msg [8];
    int          n;
    logic [15:0] pw;
    n = 0;
    if (it.kind == KIND_TICK) begin
      if (reports_on) begin
        pw[15] = it.pc[7]; pw[14] = it.pa[6]; pw[13] = it.pd[6]; pw[12] = it.pa[7];
        pw[11] = it.pc[6]; pw[10] = it.pb[4]; pw[9]  = it.pc[5]; pw[8]  = it.pa[5];
        pw[7]  = it.pc[4]; pw[6]  = it.pe[4]; pw[5]  = it.pb[3]; pw[4]  = it.pe[5];
        pw[3]  = it.pf[3]; pw[2]  = it.pb[0]; pw[1]  = it.pf[2]; pw[0]  = it.pb[1];
        for (int k = 0; k < 3; k++) msg[k] = REPORT_HEAD[k];
        for (int k = 0; k < 4; k++) msg[3 + k] = hex_ascii(pw[15 - 4 * k -: 4]);
        msg[7] = CH_CR;
        n = 8;
        reports_sent++;
      end
    end else if (it.rx == CH_CR) begin
      // end of line: terminate if there is room, then decode
      if (line_fill < LINE_DEPTH) line_mem[line_fill] = CH_NUL;
      line_fill = 0;
      if (line_starts(SETUP_CMD)) begin
        for (int k = 0; k < 6; k++) msg[k] = SETUP_REPLY[k];
        msg[6] = CH_CR;
        n = 7;
        reports_on = 1'b1;
      end else if (line_starts(MAW_CMD)) begin
        held_word = {nibble_of(line_mem[4]), nibble_of(line_mem[5]),
                     nibble_of(line_mem[6]), nibble_of(line_mem[7])};
        word_loads++;
      end else if (line_starts(RST_CMD)) begin
        reports_on = 1'b0;
      end
    end else if (line_fill < LINE_DEPTH) begin
      line_mem[line_fill] = it.rx;
      line_fill++;
    end else begin
      bytes_dropped++;
    end

    if (n == 0) frame_q.push_back(frame_for(8'h00, 1'b0, 1'b1));
    for (int k = 0; k < n; k++) frame_q.push_back(frame_for(msg[k], 1'b1, k == n - 1));
  endtask

  // ---------------------------------------------------------------- sender

  function automatic bridge_item_t rand_item(item_kind_e kind, logic [7:0] ch);
    bridge_item_t it;
    it.kind = kind;
    it.rx = ch;
    it.pa = 8'($urandom);
    it.pb = 8'($urandom);
    it.pc = 8'($urandom);
    it.pd = 8'($urandom);
    it.pe = 8'($urandom);
    it.pf = 8'($urandom);
    return it;
  endfunction

  // offer one item after a random gap; predict on transfer
  task automatic send_item(bridge_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= it.kind;
    in_rx_byte   <= it.rx;
    in_pins_a_in <= it.pa;
    in_pins_b_in <= it.pb;
    in_pins_c_in <= it.pc;
    in_pins_d_in <= it.pd;
    in_pins_e_in <= it.pe;
    in_pins_f_in <= it.pf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bridge_step(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] ch);
    send_item(rand_item(KIND_RX_BYTE, ch));
  endtask

  task automatic send_tick();
    send_item(rand_item(KIND_TICK, 8'($urandom)));
  endtask

  task automatic send_text(string s, bit end_line);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    if (end_line) send_byte(CH_CR);
  endtask

  // mostly valid hex digits, sometimes any byte
  task automatic send_hex_digits(int n);
    string digits = "0123456789ABCDEFabcdef";
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom));
      else send_byte(digits[$urandom_range(0, digits.len() - 1)]);
    end
  endtask

  // stop offering and let every predicted transfer come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
        long_holds++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= 30) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("transfer %0d %s: got %h, expected %h",
                                frames_checked, name, got, want));
  endtask

  always @(posedge clk) begin : check_frames
    tx_frame_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, tx_byte %h", out_tx_byte));
      end else begin
        want = frame_q.pop_front();
        compare_field("tx_byte", out_tx_byte, want.ch);
        compare_field("tx_valid", 8'(out_tx_valid), 8'(want.ch_valid));
        compare_field("last", 8'(out_last), 8'(want.fin));
        compare_field("pins_a_out", out_pins_a_out, want.pa);
        compare_field("pins_b_out", out_pins_b_out, want.pb);
        compare_field("pins_d_out", out_pins_d_out, want.pd);
        compare_field("pins_e_out", out_pins_e_out, want.pe);
        compare_field("pins_f_out", out_pins_f_out, want.pf);
        compare_field("reporting_on", 8'(out_reporting_on), 8'(want.rep));
        frames_checked++;
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               QUIET_LIMIT, frame_q.size());
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // every command, pin extremes, empty line, stale digits, ticks while off
  task automatic test_directed();
    bridge_item_t it;
    send_tick();
    // empty line matches setup0 by the prefix rule
    send_byte(CH_CR);
    it = rand_item(KIND_TICK, 8'hFF);
    it.pa = 8'hFF; it.pb = 8'hFF; it.pc = 8'hFF;
    it.pd = 8'hFF; it.pe = 8'hFF; it.pf = 8'hFF;
    send_item(it);
    it.pa = 8'h00; it.pb = 8'h00; it.pc = 8'h00;
    it.pd = 8'h00; it.pe = 8'h00; it.pf = 8'h00;
    send_item(it);
    // digit, lower and upper case letters, zero
    send_text("MAW=9aF0", 1'b1);
    // no digits: reads the terminator and stale bytes after it
    send_text(MAW_CMD, 1'b1);
    send_text(RST_CMD, 1'b1);
    send_tick();
    wait_drained();
  endtask

  // lines that fill the buffer; extra bytes are dropped
  task automatic test_full_line();
    int extra;
    int sent;
    for (int r = 0; r < 4; r++) begin
      extra = (r == 3) ? 0 : $urandom_range(1, 6);
      if (r == 0) begin
        send_text(MAW_CMD, 1'b0);
        send_hex_digits(4);
        sent = 8;
      end else if (r == 1) begin
        send_text(SETUP_CMD, 1'b0);
        sent = 6;
      end else begin
        sent = 0;
      end
      repeat (LINE_DEPTH + extra - sent) send_byte(8'($urandom));
      send_byte(CH_CR);
      send_tick();
    end
    wait_drained();
  endtask

  // mostly well-formed commands with random content, plus noise
  task automatic test_random_lines(int target);
    string broken [4] = '{"MAW", "se", "RSX", "sETUP0"};
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_text(MAW_CMD, 1'b0);
        send_hex_digits($urandom_range(3, 5));
        send_byte(CH_CR);
      end else if (pick < 45) begin
        send_text(SETUP_CMD, 1'b1);
      end else if (pick < 55) begin
        send_text(RST_CMD, 1'b1);
      end else if (pick < 62) begin
        send_text(broken[$urandom_range(0, 3)], 1'b1);
      end else if (pick < 72) begin
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
        if ($urandom_range(0, 1) == 1) send_byte(CH_CR);
      end else begin
        repeat ($urandom_range(1, 3)) send_tick();
      end
    end
    wait_drained();
  endtask

  // receiver holds off while full reports keep coming
  task automatic test_backpressure();
    send_text(SETUP_CMD, 1'b1);
    wait_drained();
    rx_hold_cycles = HOLD_CYCLES;
    repeat (6) send_tick();
    wait_drained();
  endtask

  // back-to-back transfers on both sides
  task automatic test_streaming();
    no_idle = 1'b1;
    send_text(SETUP_CMD, 1'b1);
    repeat (4) send_tick();
    send_text(MAW_CMD, 1'b0);
    send_hex_digits(4);
    send_byte(CH_CR);
    send_text(RST_CMD, 1'b1);
    send_tick();
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = 8'h00;
    line_fill = 0;
    reports_on = 1'b0;
    held_word = 16'h0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_line();
    test_random_lines(210);
    test_backpressure();
    test_streaming();

    repeat (8) @(posedge clk);
    $display("run covered %0d items, %0d result transfers, %0d pin reports, %0d word loads",
             items_sent, frames_checked, reports_sent, word_loads);
    $display("bytes dropped on full lines: %0d, long receiver holds: %0d",
             bytes_dropped, long_holds);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
